// ===== rtl/dfs_pkg.sv =====
`default_nettype none
package dfs_pkg;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_LOAD   = 3'd1;
	localparam logic [2:0] CMD_INPUT  = 3'd2;
	localparam logic [2:0] CMD_OUTPUT = 3'd3;
	localparam logic [2:0] CMD_RUN    = 3'd4;

	localparam logic [2:0] KIND_BUF  = 3'd0;
	localparam logic [2:0] KIND_INV  = 3'd1;
	localparam logic [2:0] KIND_AND  = 3'd2;
	localparam logic [2:0] KIND_OR   = 3'd3;
	localparam logic [2:0] KIND_NAND = 3'd4;
	localparam logic [2:0] KIND_NOR  = 3'd5;

	localparam int FSET_W = 64;
	localparam int VAL_W  = 16;
	localparam int CNT_W  = 7;

	typedef struct packed {
		logic [2:0]  command;
		logic [5:0]  gate_slot;
		logic [2:0]  gate_kind;
		logic [5:0]  net_first;
		logic [5:0]  net_second;
		logic [5:0]  net_driven;
		logic [15:0] pattern;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  output_values;
		logic [FSET_W-1:0] detected_set;
		logic [CNT_W-1:0]  detected_count;
		logic              incomplete;
	} res_t;

	typedef struct packed {
		logic run_init;
		logic pass_fault;
		logic fault_pass;
		logic in_step;
		logic sweep_restart;
		logic slot_addr;
		logic slot_chk;
		logic slot_ex;
		logic out_addr;
		logic out_acc;
		logic cnt_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_done;
		logic slot_done;
		logic progress;
		logic out_done;
		logic cnt_last;
	} ctrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/dfs_ctrl.sv =====
`default_nettype none
module dfs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         command,
	input  wire dfs_pkg::ctrl_sts_t sts,
	output dfs_pkg::ctrl_cmd_t      cmd,
	output logic                    busy
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_INP  = 4'd2;
	localparam logic [3:0] ST_SA   = 4'd3;
	localparam logic [3:0] ST_SC   = 4'd4;
	localparam logic [3:0] ST_SE   = 4'd5;
	localparam logic [3:0] ST_SEND = 4'd6;
	localparam logic [3:0] ST_OA   = 4'd7;
	localparam logic [3:0] ST_OC   = 4'd8;
	localparam logic [3:0] ST_CNT  = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0] state_q, state_d;
	logic       pass_q, pass_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		cmd     = '0;
		cmd.fault_pass = pass_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && command == dfs_pkg::CMD_RUN) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.run_init = 1'b1;
				pass_d  = 1'b0;
				state_d = ST_INP;
			end
			ST_INP: begin
				if (sts.in_done) begin
					cmd.sweep_restart = 1'b1;
					state_d = ST_SA;
				end else begin
					cmd.in_step = 1'b1;
				end
			end
			ST_SA: begin
				if (sts.slot_done) begin
					state_d = ST_SEND;
				end else begin
					cmd.slot_addr = 1'b1;
					state_d = ST_SC;
				end
			end
			ST_SC: begin
				cmd.slot_chk = 1'b1;
				state_d = ST_SE;
			end
			ST_SE: begin
				cmd.slot_ex = 1'b1;
				state_d = ST_SA;
			end
			ST_SEND: begin
				if (sts.progress) begin
					cmd.sweep_restart = 1'b1;
					state_d = ST_SA;
				end else if (!pass_q) begin
					cmd.pass_fault = 1'b1;
					pass_d  = 1'b1;
					state_d = ST_INP;
				end else begin
					state_d = ST_OA;
				end
			end
			ST_OA: begin
				if (sts.out_done) begin
					state_d = ST_CNT;
				end else begin
					cmd.out_addr = 1'b1;
					state_d = ST_OC;
				end
			end
			ST_OC: begin
				cmd.out_acc = 1'b1;
				state_d = ST_OA;
			end
			ST_CNT: begin
				cmd.cnt_step = 1'b1;
				if (sts.cnt_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	a_busy_ends_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(cmd.finish))
		else $error("busy dropped without a finished run");
	a_chk_after_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_chk |-> $past(cmd.slot_addr))
		else $error("slot check without table read");
	a_ex_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_ex |-> $past(cmd.slot_chk))
		else $error("slot execute without check");
	a_acc_after_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_acc |-> $past(cmd.out_addr))
		else $error("output accumulate without read");

endmodule
`default_nettype wire

// ===== rtl/dfs_datapath.sv =====
`default_nettype none
module dfs_datapath #(
	parameter int MAX_NETS    = 32,
	parameter int MAX_GATES   = 64,
	parameter int MAX_INPUTS  = 16,
	parameter int MAX_OUTPUTS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire dfs_pkg::req_t               request,
	input  wire dfs_pkg::ctrl_cmd_t          cmd,
	output dfs_pkg::ctrl_sts_t               sts,
	input  wire logic                        mask_we,
	input  wire logic [dfs_pkg::FSET_W-1:0]  mask_wdata,
	output logic [dfs_pkg::FSET_W-1:0]       mask,
	output logic                             done,
	output dfs_pkg::res_t                    result
);

	localparam int NW  = $clog2(MAX_NETS);
	localparam int GW  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int GTW = $clog2(MAX_GATES + 1);
	localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int ITW = $clog2(MAX_INPUTS + 1);
	localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int OTW = $clog2(MAX_OUTPUTS + 1);
	localparam int EW  = 3 + 3 * NW;
	localparam int FW  = dfs_pkg::FSET_W;
	localparam int VAL_W_L = dfs_pkg::VAL_W;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) c = c + {3'd0, v[i]};
		return c;
	endfunction

	// netlist storage
	logic [EW-1:0]  gate_mem [MAX_GATES];
	logic [GTW-1:0] gate_total_q;
	logic [NW-1:0]  in_nets_q [MAX_INPUTS];
	logic [ITW-1:0] in_total_q;
	logic [NW-1:0]  out_nets_q [MAX_OUTPUTS];
	logic [OTW-1:0] out_total_q;
	logic [FW-1:0]  mask_q;

	// run state
	logic [FW-1:0]        fault_mem [MAX_NETS];
	logic [MAX_NETS-1:0]  val_q, rdy_q, fw_q;
	logic [MAX_GATES-1:0] evald_q;
	logic [15:0]          pat_q;
	logic [ITW-1:0]       in_i_q;
	logic [GTW-1:0]       slot_q;
	logic [OTW-1:0]       out_i_q;
	logic [2:0]           cnt_k_q;
	logic                 progress_q, go_q;
	logic [EW-1:0]        gate_rd_s1;
	logic [NW-1:0]        onet_s1;
	logic [FW-1:0]        fa_s2, fb_s2;
	logic [FW-1:0]        det_q;
	logic [VAL_W_L-1:0]   vals_q;
	logic [dfs_pkg::CNT_W-1:0] count_q;
	logic                 done_q;
	dfs_pkg::res_t        res_q;

	// load, input and output command decode
	logic          is_load, is_in, is_out;
	logic          n1_ok, n2_ok, nd_ok, slot_ok;
	logic [NW-1:0] n1_idx, n2_idx, nd_idx;
	logic [GTW-1:0] slot_next;

	assign n1_ok  = request.net_first != 6'd0 && int'(request.net_first) <= MAX_NETS;
	assign n2_ok  = request.net_second != 6'd0 && int'(request.net_second) <= MAX_NETS;
	assign nd_ok  = request.net_driven != 6'd0 && int'(request.net_driven) <= MAX_NETS;
	assign n1_idx = NW'(request.net_first - 6'd1);
	assign n2_idx = NW'(request.net_second - 6'd1);
	assign nd_idx = NW'(request.net_driven - 6'd1);
	assign slot_ok = int'(request.gate_slot) < MAX_GATES;
	assign slot_next = GTW'(request.gate_slot) + GTW'(1);

	assign is_load = accept && request.command == dfs_pkg::CMD_LOAD && slot_ok
		&& request.gate_kind <= dfs_pkg::KIND_NOR && n1_ok && nd_ok
		&& (request.gate_kind < dfs_pkg::KIND_AND || n2_ok);
	assign is_in  = accept && request.command == dfs_pkg::CMD_INPUT && n1_ok
		&& int'(in_total_q) < MAX_INPUTS;
	assign is_out = accept && request.command == dfs_pkg::CMD_OUTPUT && n1_ok
		&& int'(out_total_q) < MAX_OUTPUTS;

	always_ff @(posedge clk) begin
		if (is_load)
			gate_mem[GW'(request.gate_slot)] <= {request.gate_kind, n1_idx,
				(request.gate_kind < dfs_pkg::KIND_AND) ? {NW{1'b0}} : n2_idx, nd_idx};
		if (is_in)  in_nets_q[in_total_q[IW-1:0]] <= n1_idx;
		if (is_out) out_nets_q[out_total_q[OW-1:0]] <= n1_idx;
		if (accept && request.command == dfs_pkg::CMD_RUN) pat_q <= request.pattern;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_total_q <= '0;
			in_total_q   <= '0;
			out_total_q  <= '0;
			mask_q       <= '1;
		end else begin
			if (mask_we) mask_q <= mask_wdata;
			if (accept && request.command == dfs_pkg::CMD_CLEAR) begin
				gate_total_q <= '0;
				in_total_q   <= '0;
				out_total_q  <= '0;
			end
			if (is_load && slot_next > gate_total_q) gate_total_q <= slot_next;
			if (is_in)  in_total_q  <= in_total_q + ITW'(1);
			if (is_out) out_total_q <= out_total_q + OTW'(1);
		end
	end

	assign mask = mask_q;

	// current gate entry
	logic [2:0]    g_kind;
	logic [NW-1:0] g_a, g_b, g_d;
	logic          va, vb, good_v, ctl, good_f;
	logic [FW-1:0] fa, fb, set_base, fbit, set_f;

	assign g_kind = gate_rd_s1[EW-1 -: 3];
	assign g_a    = gate_rd_s1[3*NW-1 -: NW];
	assign g_b    = gate_rd_s1[2*NW-1 -: NW];
	assign g_d    = gate_rd_s1[NW-1:0];
	assign va     = val_q[g_a];
	assign vb     = val_q[g_b];
	assign fa     = fw_q[g_a] ? fa_s2 : '0;
	assign fb     = fw_q[g_b] ? fb_s2 : '0;

	always_comb begin
		case (g_kind)
			dfs_pkg::KIND_BUF:  good_v = va;
			dfs_pkg::KIND_INV:  good_v = ~va;
			dfs_pkg::KIND_AND:  good_v = va & vb;
			dfs_pkg::KIND_OR:   good_v = va | vb;
			dfs_pkg::KIND_NAND: good_v = ~(va & vb);
			default:            good_v = ~(va | vb);
		endcase
	end

	// deductive rule: controlling inputs decide intersection, difference or union
	always_comb begin
		ctl = !(g_kind == dfs_pkg::KIND_AND || g_kind == dfs_pkg::KIND_NAND);
		if (g_kind < dfs_pkg::KIND_AND) begin
			set_base = fa;
			good_f   = (g_kind == dfs_pkg::KIND_BUF) ? va : ~va;
		end else begin
			if (va == ctl && vb == ctl) set_base = fa & fb;
			else if (va == ctl)         set_base = fa & ~fb;
			else if (vb == ctl)         set_base = fb & ~fa;
			else                        set_base = fa | fb;
			good_f = val_q[g_d];
		end
		fbit  = FW'(1) << {g_d, ~good_f};
		set_f = set_base | (fbit & mask_q);
	end

	// input net for the current step
	logic [NW-1:0] in_net;
	logic [FW-1:0] in_fbit;
	assign in_net  = in_nets_q[in_i_q[IW-1:0]];
	assign in_fbit = FW'(1) << {in_net, ~val_q[in_net]};

	// fault memory write port
	logic          fm_we;
	logic [NW-1:0] fm_addr;
	logic [FW-1:0] fm_wdata;

	always_comb begin
		fm_we    = 1'b0;
		fm_addr  = g_d;
		fm_wdata = set_f;
		if (cmd.in_step && cmd.fault_pass) begin
			fm_we    = 1'b1;
			fm_addr  = in_net;
			fm_wdata = in_fbit;
		end else if (cmd.slot_ex && cmd.fault_pass && go_q) begin
			fm_we = 1'b1;
		end
	end

	logic [NW-1:0] out_net;
	assign out_net = out_nets_q[out_i_q[OW-1:0]];

	always_ff @(posedge clk) begin
		if (fm_we) fault_mem[fm_addr] <= fm_wdata;
		if (cmd.slot_addr) gate_rd_s1 <= gate_mem[slot_q[GW-1:0]];
		if (cmd.slot_chk) begin
			fa_s2 <= fault_mem[g_a];
			fb_s2 <= fault_mem[g_b];
			go_q  <= !evald_q[slot_q[GW-1:0]] && rdy_q[g_a]
				&& (g_kind < dfs_pkg::KIND_AND || rdy_q[g_b]);
		end else if (cmd.out_addr) begin
			fa_s2   <= fault_mem[out_net];
			onet_s1 <= out_net;
		end
	end

	logic inc;
	always_comb begin
		inc = 1'b0;
		for (int i = 0; i < MAX_GATES; i++)
			if (!evald_q[i] && i < int'(gate_total_q)) inc = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q      <= '0;
			rdy_q      <= '0;
			fw_q       <= '0;
			evald_q    <= '0;
			in_i_q     <= '0;
			slot_q     <= '0;
			out_i_q    <= '0;
			cnt_k_q    <= '0;
			progress_q <= 1'b0;
			det_q      <= '0;
			vals_q     <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.run_init) begin
				val_q   <= '0;
				rdy_q   <= '0;
				fw_q    <= '0;
				evald_q <= '0;
				in_i_q  <= '0;
				out_i_q <= '0;
				cnt_k_q <= '0;
				det_q   <= '0;
				vals_q  <= '0;
				count_q <= '0;
			end
			if (cmd.pass_fault) begin
				rdy_q   <= '0;
				evald_q <= '0;
				in_i_q  <= '0;
			end
			if (cmd.in_step) begin
				rdy_q[in_net] <= 1'b1;
				if (cmd.fault_pass) fw_q[in_net] <= 1'b1;
				else val_q[in_net] <= pat_q[in_i_q[IW-1:0]];
				in_i_q <= in_i_q + ITW'(1);
			end
			if (cmd.sweep_restart) begin
				slot_q     <= '0;
				progress_q <= 1'b0;
			end
			if (cmd.slot_ex) begin
				if (go_q) begin
					if (cmd.fault_pass) fw_q[g_d] <= 1'b1;
					else val_q[g_d] <= good_v;
					rdy_q[g_d] <= 1'b1;
					evald_q[slot_q[GW-1:0]] <= 1'b1;
					progress_q <= 1'b1;
				end
				slot_q <= slot_q + GTW'(1);
			end
			if (cmd.out_acc) begin
				if (fw_q[onet_s1]) det_q <= det_q | fa_s2;
				vals_q[out_i_q[OW-1:0]] <= val_q[onet_s1];
				out_i_q <= out_i_q + OTW'(1);
			end
			if (cmd.cnt_step) begin
				count_q <= count_q + {3'd0, pop8(det_q[{cnt_k_q, 3'b000} +: 8])};
				cnt_k_q <= cnt_k_q + 3'd1;
			end
			if (cmd.finish) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.output_values  <= vals_q;
			res_q.detected_set   <= det_q;
			res_q.detected_count <= count_q;
			res_q.incomplete     <= inc;
		end
	end

	assign sts.in_done   = (in_i_q == in_total_q);
	assign sts.slot_done = (slot_q == gate_total_q);
	assign sts.progress  = progress_q;
	assign sts.out_done  = (out_i_q == out_total_q);
	assign sts.cnt_last  = (cnt_k_q == 3'd7);

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

// ===== rtl/gate_netlist_deductive_fault_sim.sv =====
`default_nettype none
// Deductive stuck-at fault simulator for a small two-input gate netlist.
// Commands enter on request when start is high and busy is low. Clear, load
// gate, declare input and declare output complete in the accepting cycle and
// raise no busy. A run raises busy and later presents one result on result,
// marked by done for a single cycle; the receiver cannot hold it off.
// Runs do not overlap. A run initializes, then each pass steps through the
// declared inputs and sweeps the gate table (address, check, execute per slot)
// until a sweep evaluates nothing (at most gates+1 sweeps), for the good pass
// and again for the fault pass; then it reads and accumulates each declared
// output, counts the detected set a byte at a time and finishes. Sweeps use the
// single gate table read port and the registered two-port fault-set memory.
// fault_mask sits on the APB-style port at address 0, 64 bits wide, and may
// be written while busy is low. Reset empties the netlist (totals zero) and
// enables every fault; table and list contents are unknown until loaded.
module gate_netlist_deductive_fault_sim #(
	parameter int MAX_NETS    = 32,
	parameter int MAX_GATES   = 64,
	parameter int MAX_INPUTS  = 16,
	parameter int MAX_OUTPUTS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire dfs_pkg::req_t request,
	output logic               done,
	output dfs_pkg::res_t      result,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [63:0]   pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	dfs_pkg::ctrl_cmd_t cmd;
	dfs_pkg::ctrl_sts_t sts;
	logic               accept;
	logic               mask_we;
	logic [63:0]        mask;

	assign accept  = start && !busy;
	assign pready  = 1'b1;
	assign mask_we = psel && penable && pwrite && !paddr[3];
	assign prdata  = paddr[3] ? 64'd0 : mask;

	dfs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	dfs_datapath #(
		.MAX_NETS    (MAX_NETS),
		.MAX_GATES   (MAX_GATES),
		.MAX_INPUTS  (MAX_INPUTS),
		.MAX_OUTPUTS (MAX_OUTPUTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.request    (request),
		.cmd        (cmd),
		.sts        (sts),
		.mask_we    (mask_we),
		.mask_wdata (pwdata),
		.mask       (mask),
		.done       (done),
		.result     (result)
	);

endmodule
`default_nettype wire
